@@ design/rari_pkg.sv @@
package rari_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int TEX_BITS = 16;
  localparam int TEX_W = TEX_BITS + 1;
  localparam int MAG_W = COORD_W + FRAC_BITS;
  localparam int LATENCY = MAG_W + 21;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_X_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Z_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Z_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DOWN = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] near_limit;
    logic signed [COORD_W-1:0] far_limit;
  } ray_t;

  typedef struct packed {
    logic                      is_hit;
    logic signed [COORD_W-1:0] hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_z;
    logic                      normal_positive;
    logic                      faces_front;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
  } hit_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oz;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dz;
    logic signed [COORD_W-1:0] nearl;
    logic signed [COORD_W-1:0] farl;
    logic                      dyzero;
    logic                      dyneg;
    logic                      qsign;
    logic [COORD_W-1:0]        d;
    logic [COORD_W-1:0]        rem;
    logic [MAG_W-1:0]          n;
  } div_t;

  typedef struct packed {
    logic                      hit;
    logic                      dyneg;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oz;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dz;
    logic signed [COORD_W-1:0] t32;
  } post_t;

  typedef struct packed {
    logic                      hit;
    logic                      dyneg;
    logic signed [COORD_W-1:0] tval;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hz;
    logic [COORD_W-1:0]        ru;
    logic [COORD_W-1:0]        rv;
    logic [TEX_W-1:0]          qu;
    logic [TEX_W-1:0]          qv;
  } tex_t;

  function automatic div_t div_step(div_t s);
    logic [COORD_W:0] tr;
    logic [COORD_W:0] diff;
    div_t r;
    r = s;
    tr = {s.rem, s.n[MAG_W-1]};
    diff = tr - {1'b0, s.d};
    if (tr >= {1'b0, s.d}) begin
      r.rem = diff[COORD_W-1:0];
      r.n = {s.n[MAG_W-2:0], 1'b1};
    end else begin
      r.rem = tr[COORD_W-1:0];
      r.n = {s.n[MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [COORD_W:0] lane_step(logic [COORD_W-1:0] rem,
                                                 logic [COORD_W-1:0] ext);
    logic [COORD_W:0] tr;
    logic [COORD_W:0] diff;
    tr = {rem, 1'b0};
    diff = tr - {1'b0, ext};
    if (tr >= {1'b0, ext}) begin
      return {diff[COORD_W-1:0], 1'b1};
    end
    return {tr[COORD_W-1:0], 1'b0};
  endfunction

endpackage

@@ design/ray_axis_rect_intersect_top.sv @@
// Ray test against a rectangle in the plane y = plane_height.
// Request channel: drive request and raise start; a request is taken at each
// rising edge with start high and busy low. busy stays low, so a request can
// be issued in every cycle.
// Result channel: done is high for exactly one cycle per request, with the
// answer on result; results come back in request order. The receiver cannot
// stall and must take each result in its cycle.
// Stages: input register, 48 one-bit steps of the distance divider, interval
// test, multiply, bounds test merged with the first of 17 one-bit steps of
// the texture dividers, output register. Throughput: one request per cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// unknown indexes are ignored. Write only while no request is in flight.
// Reset: rst, synchronous, empties the pipeline and restores the register
// defaults (unit square at height 0, normal +y).
module ray_axis_rect_intersect_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rari_pkg::ray_t                 request,
  output logic                           done,
  output rari_pkg::hit_t                 result,
  input  logic                           cfg_we,
  input  logic [rari_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rari_pkg::COORD_W-1:0]   cfg_data
);
  import rari_pkg::*;

  logic signed [COORD_W-1:0] rect_x_a, rect_x_b, rect_z_a, rect_z_b, plane_height;
  logic                      normal_down;
  logic signed [COORD_W-1:0] x0, x1, z0, z1;
  logic [COORD_W-1:0]        ext_x, ext_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_x_a <= '0;
      rect_x_b <= COORD_W'(1) <<< FRAC_BITS;
      rect_z_a <= '0;
      rect_z_b <= COORD_W'(1) <<< FRAC_BITS;
      plane_height <= '0;
      normal_down <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECT_X_A:     rect_x_a <= cfg_data;
        REG_RECT_X_B:     rect_x_b <= cfg_data;
        REG_RECT_Z_A:     rect_z_a <= cfg_data;
        REG_RECT_Z_B:     rect_z_b <= cfg_data;
        REG_PLANE_HEIGHT: plane_height <= cfg_data;
        REG_NORMAL_DOWN:  normal_down <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x0 <= (rect_x_a < rect_x_b) ? rect_x_a : rect_x_b;
    x1 <= (rect_x_a < rect_x_b) ? rect_x_b : rect_x_a;
    z0 <= (rect_z_a < rect_z_b) ? rect_z_a : rect_z_b;
    z1 <= (rect_z_a < rect_z_b) ? rect_z_b : rect_z_a;
  end

  always_comb begin
    ext_x = x1 - x0;
    ext_z = z1 - z0;
  end

  assign busy = 1'b0;

  div_t dv [0:MAG_W];
  logic vd [0:MAG_W];

  logic signed [COORD_W:0] ydiff;
  logic [COORD_W:0]        ymag;
  div_t                    d0;

  always_comb begin
    ydiff = {plane_height[COORD_W-1], plane_height}
          - {request.origin_y[COORD_W-1], request.origin_y};
    ymag = ydiff[COORD_W] ? -ydiff : ydiff;
    d0.ox = request.origin_x;
    d0.oz = request.origin_z;
    d0.dx = request.dir_x;
    d0.dz = request.dir_z;
    d0.nearl = request.near_limit;
    d0.farl = request.far_limit;
    d0.dyzero = (request.dir_y == '0);
    d0.dyneg = request.dir_y[COORD_W-1];
    d0.qsign = ydiff[COORD_W] ^ request.dir_y[COORD_W-1];
    d0.d = request.dir_y[COORD_W-1] ? -request.dir_y : request.dir_y;
    d0.rem = '0;
    d0.n = {ymag[COORD_W-1:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else begin
      vd[0] <= start;
    end
    dv[0] <= d0;
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else begin
        vd[k+1] <= vd[k];
      end
      dv[k+1] <= div_step(dv[k]);
    end
  end

  logic signed [MAG_W:0] tq;
  post_t                 p1, p2;
  logic                  v1, v2;
  logic signed [2*COORD_W-1:0] px, pz;

  always_comb begin
    tq = dv[MAG_W].qsign ? -$signed({1'b0, dv[MAG_W].n}) : $signed({1'b0, dv[MAG_W].n});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= vd[MAG_W];
      v2 <= v1;
    end
    p1.hit <= !dv[MAG_W].dyzero
            && tq >= $signed({{(MAG_W+1-COORD_W){dv[MAG_W].nearl[COORD_W-1]}},
                              dv[MAG_W].nearl})
            && tq <= $signed({{(MAG_W+1-COORD_W){dv[MAG_W].farl[COORD_W-1]}},
                              dv[MAG_W].farl});
    p1.dyneg <= dv[MAG_W].dyneg;
    p1.ox <= dv[MAG_W].ox;
    p1.oz <= dv[MAG_W].oz;
    p1.dx <= dv[MAG_W].dx;
    p1.dz <= dv[MAG_W].dz;
    p1.t32 <= tq[COORD_W-1:0];
    p2 <= p1;
    px <= p1.t32 * p1.dx;
    pz <= p1.t32 * p1.dz;
  end

  logic signed [2*COORD_W:0] hx, hz;
  logic [COORD_W-1:0]        ru_raw, rv_raw;
  logic                      qhi_u, qhi_v;
  tex_t                      t0;

  always_comb begin
    hx = {{(COORD_W+1){p2.ox[COORD_W-1]}}, p2.ox}
       + {px[2*COORD_W-1], (px >>> FRAC_BITS)};
    hz = {{(COORD_W+1){p2.oz[COORD_W-1]}}, p2.oz}
       + {pz[2*COORD_W-1], (pz >>> FRAC_BITS)};
    ru_raw = hx[COORD_W-1:0] - x0;
    rv_raw = hz[COORD_W-1:0] - z0;
    qhi_u = (ext_x != '0) && (ru_raw >= ext_x);
    qhi_v = (ext_z != '0) && (rv_raw >= ext_z);
    t0.hit = p2.hit
          && hx >= $signed({{(COORD_W+1){x0[COORD_W-1]}}, x0})
          && hx <= $signed({{(COORD_W+1){x1[COORD_W-1]}}, x1})
          && hz >= $signed({{(COORD_W+1){z0[COORD_W-1]}}, z0})
          && hz <= $signed({{(COORD_W+1){z1[COORD_W-1]}}, z1});
    t0.dyneg = p2.dyneg;
    t0.tval = p2.t32;
    t0.hx = hx[COORD_W-1:0];
    t0.hz = hz[COORD_W-1:0];
    t0.ru = qhi_u ? ru_raw - ext_x : ru_raw;
    t0.rv = qhi_v ? rv_raw - ext_z : rv_raw;
    t0.qu = TEX_W'(qhi_u);
    t0.qv = TEX_W'(qhi_v);
  end

  tex_t tx [0:TEX_BITS];
  logic vt [0:TEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vt[0] <= 1'b0;
    end else begin
      vt[0] <= v2;
    end
    tx[0] <= t0;
  end

  for (genvar k = 0; k < TEX_BITS; k++) begin : g_tex
    logic [COORD_W:0] su, sv;
    tex_t             tn;
    always_comb begin
      su = lane_step(tx[k].ru, ext_x);
      sv = lane_step(tx[k].rv, ext_z);
      tn = tx[k];
      tn.ru = su[COORD_W:1];
      tn.rv = sv[COORD_W:1];
      tn.qu = {tx[k].qu[TEX_W-2:0], su[0]};
      tn.qv = {tx[k].qv[TEX_W-2:0], sv[0]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vt[k+1] <= 1'b0;
      end else begin
        vt[k+1] <= vt[k];
      end
      tx[k+1] <= tn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vt[TEX_BITS];
    end
    if (tx[TEX_BITS].hit) begin
      result.is_hit <= 1'b1;
      result.hit_distance <= tx[TEX_BITS].tval;
      result.hit_x <= tx[TEX_BITS].hx;
      result.hit_z <= tx[TEX_BITS].hz;
      result.normal_positive <= tx[TEX_BITS].dyneg;
      result.faces_front <= normal_down ? !tx[TEX_BITS].dyneg : tx[TEX_BITS].dyneg;
      result.tex_u <= (ext_x == '0) ? '0 : tx[TEX_BITS].qu;
      result.tex_v <= (ext_z == '0) ? '0 : tx[TEX_BITS].qv;
    end else begin
      result <= '0;
    end
  end

endmodule

@@ design/rari_checker.sv @@
module rari_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input rari_pkg::hit_t result
);
  import rari_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing at fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.is_hit) |-> (result == '0))
    else $error("miss with nonzero fields");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_hit) |->
      (result.tex_u <= (TEX_W'(1) << TEX_BITS) && result.tex_v <= (TEX_W'(1) << TEX_BITS)))
    else $error("texture coordinate out of range");

endmodule

bind ray_axis_rect_intersect_top rari_checker u_rari_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .result(result)
);
